FILE: rtl/core/dfp_pkg.sv
// Shared types, constants and microcode ROM of the decimal format printer.
// No dependencies; used by dfp_sequencer, dfp_datapath and the top level.
`default_nettype none
package dfp_pkg;

	// Default parameter values and fixed sizes
	localparam int ARG_SLOTS_DEF  = 3;
	localparam int COUNT_BITS_DEF = 16;
	localparam int NUM_REGS       = 3;
	localparam int DIGIT_SLOTS    = 10;
	localparam int LEN_W          = $clog2(DIGIT_SLOTS + 1);
	localparam int DIGIT_IDX_W    = $clog2(DIGIT_SLOTS);
	localparam int CFG_IDX_W      = 2;
	localparam int STEP_W         = 4;

	// Reciprocal of ten: (x * RECIP10) >> 35 is exact for every 32-bit x
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// Characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_D     = 8'h64;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ARG_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARG_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARG_THIRD  = 2'd2;

	// Payload words
	typedef struct packed {
		logic [7:0] fmt_char;
		logic       message_start;
		logic       message_end;
	} fmt_word_t;

	typedef struct packed {
		logic [7:0]  out_char;
		logic        last_of_run;
		logic [15:0] char_count;
		logic        arg_overrun;
	} chr_word_t;

	// Microcode fields
	typedef enum logic [3:0] {
		C_NEVER,
		C_NOT_ACCEPT,
		C_PEND,
		C_CH_PCT,
		C_END,
		C_NOT_D,
		C_NO_ARG,
		C_NOT_NEG,
		C_QUO_NZ,
		C_LEN_GT1
	} cond_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_WAIT_IN,
		OP_SET_PEND,
		OP_CLR_PEND,
		OP_LOAD_ARG,
		OP_CONVERT,
		OP_EMIT_DIGIT
	} op_t;

	typedef enum logic [2:0] {
		E_NONE,
		E_CHAR,
		E_PCT,
		E_LET_D,
		E_MINUS,
		E_DIGIT
	} emit_t;

	typedef enum logic [1:0] {
		L_NO,
		L_YES,
		L_LEN1
	} last_t;

	typedef struct packed {
		cond_t             cond;
		logic [STEP_W-1:0] target;
		logic              fall_idle;
		op_t               op;
		emit_t             emit;
		last_t             last;
		logic              over;
	} uword_t;

	// Sequencer to datapath
	typedef struct packed {
		logic   exec;
		uword_t uw;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic accept;
		logic pend;
		logic ch_pct;
		logic ch_d;
		logic msg_end;
		logic arg_ok;
		logic neg;
		logic quo_nz;
		logic len_gt1;
		logic out_busy;
	} status_t;

	// Step addresses
	localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
	localparam logic [STEP_W-1:0] ST_DISPATCH  = 4'd1;
	localparam logic [STEP_W-1:0] ST_PLAIN_TST = 4'd2;
	localparam logic [STEP_W-1:0] ST_PLAIN     = 4'd3;
	localparam logic [STEP_W-1:0] ST_PCT_NEW   = 4'd4;
	localparam logic [STEP_W-1:0] ST_PENDING   = 4'd5;
	localparam logic [STEP_W-1:0] ST_ARG_TST   = 4'd6;
	localparam logic [STEP_W-1:0] ST_LOAD      = 4'd7;
	localparam logic [STEP_W-1:0] ST_MINUS     = 4'd8;
	localparam logic [STEP_W-1:0] ST_CONV      = 4'd9;
	localparam logic [STEP_W-1:0] ST_DIGIT     = 4'd10;
	localparam logic [STEP_W-1:0] ST_OVR_PCT   = 4'd11;
	localparam logic [STEP_W-1:0] ST_OVR_D     = 4'd12;
	localparam logic [STEP_W-1:0] ST_ESC_PCT   = 4'd13;
	localparam logic [STEP_W-1:0] ST_ESC_CH    = 4'd14;
	localparam logic [STEP_W-1:0] ST_LONE_PCT  = 4'd15;

	// Control store: taken cond jumps to target, else fall_idle ? idle : next
	// A lone trailing percent also drops the pending mark set on the way in.
	function automatic uword_t ucode(input logic [STEP_W-1:0] pc);
		uword_t w;
		w = '{C_NEVER, ST_IDLE, 1'b1, OP_NONE, E_NONE, L_NO, 1'b0};
		case (pc)
			ST_IDLE:      w = '{C_NOT_ACCEPT, ST_IDLE, 1'b0, OP_WAIT_IN, E_NONE, L_NO, 1'b0};
			ST_DISPATCH:  w = '{C_PEND, ST_PENDING, 1'b0, OP_NONE, E_NONE, L_NO, 1'b0};
			ST_PLAIN_TST: w = '{C_CH_PCT, ST_PCT_NEW, 1'b0, OP_NONE, E_NONE, L_NO, 1'b0};
			ST_PLAIN:     w = '{C_NEVER, ST_IDLE, 1'b1, OP_NONE, E_CHAR, L_YES, 1'b0};
			ST_PCT_NEW:   w = '{C_END, ST_LONE_PCT, 1'b1, OP_SET_PEND, E_NONE, L_NO, 1'b0};
			ST_PENDING:   w = '{C_NOT_D, ST_ESC_PCT, 1'b0, OP_CLR_PEND, E_NONE, L_NO, 1'b0};
			ST_ARG_TST:   w = '{C_NO_ARG, ST_OVR_PCT, 1'b0, OP_NONE, E_NONE, L_NO, 1'b0};
			ST_LOAD:      w = '{C_NOT_NEG, ST_CONV, 1'b0, OP_LOAD_ARG, E_NONE, L_NO, 1'b0};
			ST_MINUS:     w = '{C_NEVER, ST_IDLE, 1'b0, OP_NONE, E_MINUS, L_NO, 1'b0};
			ST_CONV:      w = '{C_QUO_NZ, ST_CONV, 1'b0, OP_CONVERT, E_NONE, L_NO, 1'b0};
			ST_DIGIT:     w = '{C_LEN_GT1, ST_DIGIT, 1'b1, OP_EMIT_DIGIT, E_DIGIT, L_LEN1, 1'b0};
			ST_OVR_PCT:   w = '{C_NEVER, ST_IDLE, 1'b0, OP_NONE, E_PCT, L_NO, 1'b1};
			ST_OVR_D:     w = '{C_NEVER, ST_IDLE, 1'b1, OP_NONE, E_LET_D, L_YES, 1'b1};
			ST_ESC_PCT:   w = '{C_NEVER, ST_IDLE, 1'b0, OP_NONE, E_PCT, L_NO, 1'b0};
			ST_ESC_CH:    w = '{C_NEVER, ST_IDLE, 1'b1, OP_NONE, E_CHAR, L_YES, 1'b0};
			ST_LONE_PCT:  w = '{C_NEVER, ST_IDLE, 1'b1, OP_CLR_PEND, E_PCT, L_YES, 1'b0};
			default:      w = '{C_NEVER, ST_IDLE, 1'b1, OP_NONE, E_NONE, L_NO, 1'b0};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dfp_sequencer.sv
// Step counter and condition/jump logic over the microcode ROM.
// Depends on dfp_pkg (ucode, ctrl_t, status_t).
`default_nettype none
module dfp_sequencer (
	input  wire              clk,
	input  wire              arst_n,
	input  dfp_pkg::status_t status,
	output dfp_pkg::ctrl_t   ctrl
);
	import dfp_pkg::*;

	logic [STEP_W-1:0] pc_q;
	uword_t            uw;
	logic              taken;
	logic              stall;

	assign uw = ucode(pc_q);

	// Branch condition select
	always_comb begin
		case (uw.cond)
			C_NEVER:      taken = 1'b0;
			C_NOT_ACCEPT: taken = !status.accept;
			C_PEND:       taken = status.pend;
			C_CH_PCT:     taken = status.ch_pct;
			C_END:        taken = status.msg_end;
			C_NOT_D:      taken = !status.ch_d;
			C_NO_ARG:     taken = !status.arg_ok;
			C_NOT_NEG:    taken = !status.neg;
			C_QUO_NZ:     taken = status.quo_nz;
			C_LEN_GT1:    taken = status.len_gt1;
			default:      taken = 1'b0;
		endcase
	end

	// An emitting step holds while the output register is still full
	assign stall     = (uw.emit != E_NONE) && status.out_busy;
	assign ctrl.exec = !stall;
	assign ctrl.uw   = uw;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (!stall) begin
			if (taken) begin
				pc_q <= uw.target;
			end else if (uw.fall_idle) begin
				pc_q <= ST_IDLE;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/dfp_datapath.sv
// Datapath: argument registers, digit conversion, digit store, count and output register.
// Depends on dfp_pkg; driven by the control word from dfp_sequencer.
`default_nettype none
module dfp_datapath #(
	parameter int ARG_SLOTS  = dfp_pkg::ARG_SLOTS_DEF,
	parameter int COUNT_BITS = dfp_pkg::COUNT_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  dfp_pkg::ctrl_t                  ctrl,
	output dfp_pkg::status_t                status,
	input  wire                             fmt_valid,
	output logic                            fmt_ready,
	input  dfp_pkg::fmt_word_t              fmt_word,
	output logic                            chr_valid,
	input  wire                             chr_ready,
	output dfp_pkg::chr_word_t              chr_word,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [dfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [31:0]                      cfg_data
);
	import dfp_pkg::*;

	localparam int AIW = $clog2(ARG_SLOTS + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [31:0]           arg_q [NUM_REGS];
	logic [7:0]            ch_q;
	logic                  end_q;
	logic                  pend_q;
	logic [AIW-1:0]        arg_idx_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [31:0]           mag_q;
	logic [LEN_W-1:0]      len_q;
	logic [3:0]            digit_q [DIGIT_SLOTS];
	chr_word_t             out_q;
	logic                  out_valid_q;

	logic                   accept;
	logic                   emit_go;
	logic [31:0]            arg_val;
	logic [63:0]            prod;
	logic [31:0]            quo;
	logic [31:0]            quo_x10;
	logic [3:0]             rem;
	logic [DIGIT_IDX_W-1:0] rd_idx;
	logic [COUNT_BITS-1:0]  cnt_nxt;
	logic [7:0]             emit_char;
	logic                   emit_last;

	assign fmt_ready = (ctrl.uw.op == OP_WAIT_IN);
	assign accept    = fmt_valid && fmt_ready;
	assign cfg_ready = 1'b1;
	assign emit_go   = ctrl.exec && (ctrl.uw.emit != E_NONE);

	// Argument for the current slot; slots past the registers read as zero
	always_comb begin
		arg_val = '0;
		for (int i = 0; i < NUM_REGS; i++) begin
			if (32'(arg_idx_q) == 32'(i)) begin
				arg_val = arg_q[i];
			end
		end
	end

	// One decimal digit per step: quotient by reciprocal, remainder by shift-add
	assign prod    = {32'd0, mag_q} * {32'd0, RECIP10};
	assign quo     = 32'(prod >> RECIP_SHIFT);
	assign quo_x10 = (quo << 3) + (quo << 1);
	assign rem     = 4'(mag_q - quo_x10);
	assign rd_idx  = DIGIT_IDX_W'(len_q - 1'b1);

	// Saturating character count
	assign cnt_nxt = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;

	// Character select
	always_comb begin
		case (ctrl.uw.emit)
			E_CHAR:  emit_char = ch_q;
			E_PCT:   emit_char = CH_PCT;
			E_LET_D: emit_char = CH_D;
			E_MINUS: emit_char = CH_MINUS;
			E_DIGIT: emit_char = CH_ZERO + {4'd0, digit_q[rd_idx]};
			default: emit_char = CH_ZERO;
		endcase
	end

	always_comb begin
		case (ctrl.uw.last)
			L_YES:   emit_last = 1'b1;
			L_LEN1:  emit_last = (len_q == LEN_W'(1));
			default: emit_last = 1'b0;
		endcase
	end

	// Status back to the sequencer; sign is taken from the slot being loaded
	assign status.accept   = accept;
	assign status.pend     = pend_q;
	assign status.ch_pct   = (ch_q == CH_PCT);
	assign status.ch_d     = (ch_q == CH_D);
	assign status.msg_end  = end_q;
	assign status.arg_ok   = (32'(arg_idx_q) < 32'(ARG_SLOTS));
	assign status.neg      = arg_val[31];
	assign status.quo_nz   = (quo != 32'd0);
	assign status.len_gt1  = (len_q > LEN_W'(1));
	assign status.out_busy = out_valid_q && !chr_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				arg_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ARG_FIRST:  arg_q[0] <= cfg_data;
				REG_ARG_SECOND: arg_q[1] <= cfg_data;
				REG_ARG_THIRD:  arg_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state: pending percent, argument slot, count, digit length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			arg_idx_q   <= '0;
			cnt_q       <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && fmt_word.message_start) begin
				pend_q    <= 1'b0;
				arg_idx_q <= '0;
				cnt_q     <= '0;
			end
			if (ctrl.exec) begin
				case (ctrl.uw.op)
					OP_SET_PEND:   pend_q <= 1'b1;
					OP_CLR_PEND:   pend_q <= 1'b0;
					OP_LOAD_ARG: begin
						arg_idx_q <= arg_idx_q + 1'b1;
						len_q     <= '0;
					end
					OP_CONVERT:    len_q <= len_q + 1'b1;
					OP_EMIT_DIGIT: len_q <= len_q - 1'b1;
					default: ;
				endcase
			end
			if (emit_go) begin
				cnt_q       <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (chr_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q  <= fmt_word.fmt_char;
			end_q <= fmt_word.message_end;
		end
		if (ctrl.exec && ctrl.uw.op == OP_LOAD_ARG) begin
			mag_q <= arg_val[31] ? (32'd0 - arg_val) : arg_val;
		end
		if (ctrl.exec && ctrl.uw.op == OP_CONVERT) begin
			digit_q[DIGIT_IDX_W'(len_q)] <= rem;
			mag_q                        <= quo;
		end
		if (emit_go) begin
			out_q.out_char    <= emit_char;
			out_q.last_of_run <= emit_last;
			out_q.char_count  <= 16'(32'(cnt_nxt));
			out_q.arg_overrun <= ctrl.uw.over;
		end
	end

	assign chr_valid = out_valid_q;
	assign chr_word  = out_q;

	// Output word never overwritten while it waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |-> !(out_valid_q && !chr_ready))
		else $error("output word overwritten while held");

	// Digit store never holds more than ten digits; reads need one present
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q <= LEN_W'(DIGIT_SLOTS)) &&
		(!(ctrl.exec && ctrl.uw.emit == E_DIGIT) || len_q != '0))
		else $error("digit length out of range");

	// Overrun flag marks only the literal percent and d
	a_overrun_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.arg_overrun |->
			out_q.out_char == CH_PCT || out_q.out_char == CH_D)
		else $error("overrun flag on unexpected character");

endmodule
`default_nettype wire

FILE: rtl/core/decimal_format_printer.sv
// Decimal format printer: dfp_sequencer microcode over dfp_datapath, types in dfp_pkg.
// Each format character runs as microcode steps; a new word is taken only in the idle step,
// once the previous word is done. %d converts through the digit loop (one divide-by-ten
// step per cycle, then one digit out per cycle while the output does not stall).
// Each result is registered by an emitting step; output stalls hold the step.
// Asynchronous active-low reset: idle step, argument registers zero, no clearing pass.
`default_nettype none
module decimal_format_printer #(
	parameter int ARG_SLOTS  = dfp_pkg::ARG_SLOTS_DEF,
	parameter int COUNT_BITS = dfp_pkg::COUNT_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          fmt_valid,
	output logic                         fmt_ready,
	input  dfp_pkg::fmt_word_t           fmt_word,
	output logic                         chr_valid,
	input  wire                          chr_ready,
	output dfp_pkg::chr_word_t           chr_word,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [dfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [31:0]                   cfg_data
);
	import dfp_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	// Control store and step counter
	dfp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// Datapath
	dfp_datapath #(
		.ARG_SLOTS  (ARG_SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.fmt_valid (fmt_valid),
		.fmt_ready (fmt_ready),
		.fmt_word  (fmt_word),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready),
		.chr_word  (chr_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for decimal_format_printer: directed rows and random messages,
// each word checked against its typed text or a behavioral predictor.
// Depends on dfp_pkg and the decimal_format_printer RTL.
module testbench;
	import dfp_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 250;
	localparam int PHASES       = 5;
	localparam int DIR_ROWS     = 25;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [15:0]          COUNT_MAX  = 16'hFFFF;
	localparam logic [31:0]          ARG_MIN    = 32'h8000_0000;
	localparam logic [31:0]          ARG_MAX    = 32'h7FFF_FFFF;
	localparam logic [31:0]          ARG_NEG1   = 32'hFFFF_FFFF;

	// Directed row: format word plus, where obvious, the text it must print
	typedef struct packed {
		fmt_word_t   w;
		logic        typed;
		logic        over;
		logic [3:0]  n_out;
		logic [87:0] text;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 fmt_valid;
	logic                 fmt_ready;
	fmt_word_t            fmt_word;
	logic                 chr_valid;
	logic                 chr_ready;
	chr_word_t            chr_word;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	// Predictor state
	logic [31:0] arg_val [NUM_REGS];
	logic        pct_held;
	int unsigned next_arg;
	logic [15:0] msg_count;
	chr_word_t   step_out[$];
	chr_word_t   char_queue[$];
	fmt_word_t   msg_q[$];

	// Traffic shaping
	int   burst_left;
	bit   tx_gaps;
	bit   rx_stalls;
	int   rx_left;
	bit   rx_hold;
	int   idle_cycles;
	int   mismatches;
	chr_word_t due;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{"A", 1'b1, 1'b0}, 1'b1, 1'b0, 4'd1, "A"},
		'{'{CH_PCT, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd0, 88'd0},
		'{'{CH_D, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd11, "-2147483648"},
		'{'{CH_PCT, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd0, 88'd0},
		'{'{CH_D, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd1, "0"},
		'{'{CH_PCT, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd0, 88'd0},
		'{'{CH_D, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd10, "2147483647"},
		// fourth %d: no argument left
		'{'{CH_PCT, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd0, 88'd0},
		'{'{CH_D, 1'b0, 1'b0}, 1'b1, 1'b1, 4'd2, "%d"},
		'{'{CH_PCT, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd0, 88'd0},
		'{'{CH_PCT, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd2, "%%"},
		'{'{CH_PCT, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd0, 88'd0},
		'{'{"x", 1'b0, 1'b0}, 1'b1, 1'b0, 4'd2, "%x"},
		'{'{8'hFF, 1'b0, 1'b0}, 1'b0, 1'b0, 4'd0, 88'd0},
		'{'{8'h01, 1'b0, 1'b0}, 1'b0, 1'b0, 4'd0, 88'd0},
		'{'{8'h80, 1'b0, 1'b0}, 1'b0, 1'b0, 4'd0, 88'd0},
		// trailing percent printed alone
		'{'{CH_PCT, 1'b0, 1'b1}, 1'b1, 1'b0, 4'd1, "%"},
		// pending percent closed by a percent at message end
		'{'{CH_PCT, 1'b1, 1'b0}, 1'b1, 1'b0, 4'd0, 88'd0},
		'{'{CH_PCT, 1'b0, 1'b1}, 1'b1, 1'b0, 4'd2, "%%"},
		// unfinished message: new start drops the pending percent
		'{'{CH_PCT, 1'b1, 1'b0}, 1'b1, 1'b0, 4'd0, 88'd0},
		'{'{"Z", 1'b1, 1'b0}, 1'b1, 1'b0, 4'd1, "Z"},
		'{'{CH_PCT, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd0, 88'd0},
		'{'{CH_D, 1'b0, 1'b0}, 1'b1, 1'b0, 4'd11, "-2147483648"},
		'{'{"q", 1'b1, 1'b1}, 1'b1, 1'b0, 4'd1, "q"},
		'{'{CH_PCT, 1'b1, 1'b1}, 1'b1, 1'b0, 4'd1, "%"}
	};

	decimal_format_printer #(
		.ARG_SLOTS (ARG_SLOTS_DEF),
		.COUNT_BITS(COUNT_BITS_DEF)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.fmt_valid(fmt_valid),
		.fmt_ready(fmt_ready),
		.fmt_word (fmt_word),
		.chr_valid(chr_valid),
		.chr_ready(chr_ready),
		.chr_word (chr_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Print one character, count saturates
	function automatic void put_char(logic [7:0] ch, logic over);
		chr_word_t c;
		if (msg_count != COUNT_MAX)
			msg_count++;
		c.out_char    = ch;
		c.last_of_run = 1'b0;
		c.char_count  = msg_count;
		c.arg_overrun = over;
		step_out.push_back(c);
	endfunction

	// Signed decimal, most significant digit first
	function automatic void put_decimal(logic [31:0] v);
		logic [31:0] mag;
		logic [3:0]  digs [DIGIT_SLOTS];
		int          n;
		n   = 0;
		mag = v;
		if (v[31]) begin
			put_char(CH_MINUS, 1'b0);
			mag = 32'd0 - v;
		end
		do begin
			digs[n] = 4'(mag % 32'd10);
			n++;
			mag = mag / 32'd10;
		end while (mag != 32'd0);
		for (int i = n - 1; i >= 0; i--)
			put_char(CH_ZERO + 8'(digs[i]), 1'b0);
	endfunction

	// Characters caused by one format word, into step_out
	function automatic void format_step(fmt_word_t w);
		chr_word_t tail;
		step_out.delete();
		if (w.message_start) begin
			next_arg  = 0;
			pct_held  = 1'b0;
			msg_count = '0;
		end
		if (pct_held) begin
			pct_held = 1'b0;
			if (w.fmt_char == CH_D) begin
				if (next_arg < ARG_SLOTS_DEF) begin
					put_decimal((next_arg < NUM_REGS) ? arg_val[next_arg] : 32'd0);
					next_arg++;
				end else begin
					put_char(CH_PCT, 1'b1);
					put_char(CH_D, 1'b1);
				end
			end else begin
				put_char(CH_PCT, 1'b0);
				put_char(w.fmt_char, 1'b0);
			end
		end else if (w.fmt_char == CH_PCT) begin
			if (w.message_end)
				put_char(CH_PCT, 1'b0);
			else
				pct_held = 1'b1;
		end else begin
			put_char(w.fmt_char, 1'b0);
		end
		if (step_out.size() > 0) begin
			tail = step_out.pop_back();
			tail.last_of_run = 1'b1;
			step_out.push_back(tail);
		end
	endfunction

	function automatic void predict_word(fmt_word_t w);
		format_step(w);
		foreach (step_out[i])
			char_queue.push_back(step_out[i]);
	endfunction

	// Directed row: typed text where given, predictor otherwise
	function automatic void expect_row(dir_row_t r);
		logic [15:0] cnt;
		chr_word_t   c;
		if (!r.typed) begin
			predict_word(r.w);
		end else begin
			cnt = r.w.message_start ? 16'd0 : msg_count;
			format_step(r.w);
			for (int i = 0; i < int'(r.n_out); i++) begin
				if (cnt != COUNT_MAX)
					cnt++;
				c.out_char    = r.text[8 * (int'(r.n_out) - 1 - i) +: 8];
				c.last_of_run = (i == int'(r.n_out) - 1);
				c.char_count  = cnt;
				c.arg_overrun = r.over;
				char_queue.push_back(c);
			end
		end
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
		end
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(1, 255));
		end while (c == CH_PCT);
		return c;
	endfunction

	function automatic logic [31:0] pick_arg();
		case ($urandom_range(0, 5))
			0: return ARG_MIN;
			1: return ARG_MAX;
			2: return 32'd0;
			3: return $urandom;
			4: return $urandom_range(0, 99999);
			default: return 32'd0 - $urandom_range(1, 99999);
		endcase
	endfunction

	// Well-formed message of random tokens into msg_q
	function automatic void build_message();
		fmt_word_t w;
		int        tokens;
		int        kind;
		tokens = $urandom_range(1, 7);
		msg_q.delete();
		for (int t = 0; t < tokens; t++) begin
			kind = $urandom_range(0, 9);
			w    = '0;
			if (kind <= 3) begin
				w.fmt_char = plain_char();
				msg_q.push_back(w);
			end else if (kind <= 6) begin
				w.fmt_char = CH_PCT;
				msg_q.push_back(w);
				w.fmt_char = CH_D;
				msg_q.push_back(w);
			end else if (kind == 7) begin
				w.fmt_char = CH_PCT;
				msg_q.push_back(w);
				msg_q.push_back(w);
			end else if (kind == 8) begin
				w.fmt_char = CH_PCT;
				msg_q.push_back(w);
				do begin
					w.fmt_char = 8'($urandom_range(1, 255));
				end while (w.fmt_char == CH_D);
				msg_q.push_back(w);
			end else begin
				// bare percent: escapes the next token or trails at the end
				w.fmt_char = CH_PCT;
				msg_q.push_back(w);
			end
		end
		w = msg_q.pop_front();
		w.message_start = 1'b1;
		msg_q.push_front(w);
		w = msg_q.pop_back();
		w.message_end = 1'b1;
		msg_q.push_back(w);
	endfunction

	task automatic send_fmt(fmt_word_t w);
		fmt_word  = w;
		fmt_valid = 1'b1;
		@(posedge clk);
		while (!fmt_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Sender bursts with random gaps
	task automatic sender_pause();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			if (tx_gaps) begin
				fmt_valid = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	endtask

	task automatic send_word(fmt_word_t w);
		send_fmt(w);
		predict_word(w);
		sender_pause();
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx < NUM_REGS)
			arg_val[idx] = val;
		@(negedge clk);
	endtask

	task automatic load_args(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2);
		write_reg(REG_ARG_FIRST, a0);
		write_reg(REG_ARG_SECOND, a1);
		write_reg(REG_ARG_THIRD, a2);
		cfg_valid = 1'b0;
	endtask

	// Wait until all expected words are out, then let a pending-only word finish
	task automatic wait_drained();
		fmt_valid = 1'b0;
		while (char_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Receiver stall pattern
	always @(negedge clk) begin
		if (!rx_stalls) begin
			chr_ready <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_hold = ($urandom_range(0, 2) == 0);
				rx_left = rx_hold ? $urandom_range(1, 16) : $urandom_range(1, 12);
			end
			rx_left--;
			chr_ready <= !rx_hold;
		end
	end

	// Compare each delivered word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && chr_valid && chr_ready) begin
			if (char_queue.size() == 0) begin
				mismatches++;
				$error("out_char: expected no word, got %0d", chr_word.out_char);
			end else begin
				due = char_queue.pop_front();
				check_field("out_char", 32'(due.out_char), 32'(chr_word.out_char));
				check_field("last_of_run", 32'(due.last_of_run), 32'(chr_word.last_of_run));
				check_field("char_count", 32'(due.char_count), 32'(chr_word.char_count));
				check_field("arg_overrun", 32'(due.arg_overrun), 32'(chr_word.arg_overrun));
			end
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((fmt_valid && fmt_ready) || (chr_valid && chr_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		fmt_word_t w;
		int        sent;
		arst_n      = 1'b0;
		fmt_valid   = 1'b0;
		fmt_word    = '0;
		chr_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		idle_cycles = 0;
		mismatches  = 0;
		burst_left  = 0;
		rx_left     = 0;
		rx_hold     = 1'b0;
		tx_gaps     = 1'b1;
		rx_stalls   = 1'b1;
		pct_held    = 1'b0;
		next_arg    = 0;
		msg_count   = '0;
		foreach (arg_val[i])
			arg_val[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes in the argument slots, junk to the unused index
		load_args(ARG_MIN, 32'd0, ARG_MAX);
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);
		cfg_valid = 1'b0;
		for (int i = 0; i < DIR_ROWS; i++) begin
			send_fmt(dir_rows[i].w);
			expect_row(dir_rows[i]);
			sender_pause();
		end

		// Random messages over several argument settings
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 1) begin
				wait_drained();
				load_args(ARG_MAX, ARG_NEG1, ARG_MIN);
			end else if (phase > 1) begin
				wait_drained();
				load_args(pick_arg(), pick_arg(), pick_arg());
			end
			tx_gaps   = (phase != 1);
			rx_stalls = (phase != 3);
			sent      = 0;
			while (sent < RANDOM_ITEMS / PHASES) begin
				if ($urandom_range(0, 6) == 0) begin
					// noise: arbitrary words and message flags
					w = fmt_word_t'({8'($urandom_range(1, 255)), 2'($urandom_range(0, 3))});
					send_word(w);
					sent++;
				end else begin
					build_message();
					foreach (msg_q[i])
						send_word(msg_q[i]);
					sent += msg_q.size();
				end
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: decimal_format_printer.f
rtl/core/dfp_pkg.sv
rtl/core/dfp_sequencer.sv
rtl/core/dfp_datapath.sv
rtl/core/decimal_format_printer.sv
sim/testbench.sv
